FILE: rtl/bpmc_pkg.sv
// ----------------------------------------------------------------------------
// bpmc_pkg: shared constants for the box pair match cost unit
// Default coordinate and cost widths used by the top level parameters.
// ----------------------------------------------------------------------------
package bpmc_pkg;

   // coordinate width, signed, 1/16 pixel units
   localparam int COORD_BITS_DEF = 20;

   // fraction bits of the unsigned cost word
   localparam int COST_FRAC_BITS_DEF = 16;

   // extra fraction bits carried by every ratio before the final divide
   localparam int GUARD_EXTRA_BITS = 2;

endpackage

FILE: rtl/box_pair_match_cost_unit.sv
// ----------------------------------------------------------------------------
// box_pair_match_cost_unit: association cost between a track and a detection
// Takes two boxes as corner pairs and returns 1 - IoU, or the combined cost
// 1 - (IoU - D + SW + SH) / 3, as an unsigned fixed point word.
// ----------------------------------------------------------------------------
// Usage:
//   req_* is the input channel: one word holds the mode bit and the eight
//   signed corner coordinates of both boxes. rsp_* is the result channel: one
//   cost word per input word, in order. Both use valid/ready.
//   From acceptance to rsp_valid a word passes through COST_FRAC_BITS + 10
//   register stages: four stages of geometry and products, one divider
//   load stage, COST_FRAC_BITS + 2 divider stages (one quotient bit each,
//   four ratios side by side), then sum, reciprocal multiply and the
//   output register.
//   Throughput is one word per cycle. Each stage moves when its successor has
//   room, so bubbles close up while the output waits; once every stage is
//   full a stalled rsp_ready holds the whole pipe and req_ready drops.
//   Reset clears all valid bits; the pipe then accepts at once.
// ----------------------------------------------------------------------------
module box_pair_match_cost_unit #(
   parameter int COORD_BITS     = bpmc_pkg::COORD_BITS_DEF,
   parameter int COST_FRAC_BITS = bpmc_pkg::COST_FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_iou_mode,
   input  logic signed [COORD_BITS-1:0] req_track_left,
   input  logic signed [COORD_BITS-1:0] req_track_top,
   input  logic signed [COORD_BITS-1:0] req_track_right,
   input  logic signed [COORD_BITS-1:0] req_track_bottom,
   input  logic signed [COORD_BITS-1:0] req_det_left,
   input  logic signed [COORD_BITS-1:0] req_det_top,
   input  logic signed [COORD_BITS-1:0] req_det_right,
   input  logic signed [COORD_BITS-1:0] req_det_bottom,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [COST_FRAC_BITS:0]      rsp_match_cost
);

   localparam int CW  = COORD_BITS;
   localparam int F   = COST_FRAC_BITS;
   localparam int K   = F + bpmc_pkg::GUARD_EXTRA_BITS;
   localparam int DW  = CW + 3;
   localparam int NW  = 2 * CW + 1;
   localparam int DS  = 4;
   localparam int NST = DS + K + 4;
   localparam int XW  = K + 1;
   localparam int RS  = XW + 2;
   localparam logic [RS-1:0]  RECIP     = RS'(((64'd1 << RS) + 64'd2) / 64'd3);
   localparam logic [K+2:0]   THREE_ONE = (K+3)'(3) << K;
   localparam logic [F:0]     ONE_F     = (F+1)'(1) << F;

   // pipeline control
   logic [NST-1:0] v_ff;
   logic [NST-1:0] mode_ff;
   logic [NST-1:0] adv;

   always_comb begin
      adv[NST-1] = !v_ff[NST-1] || rsp_ready;
      for (int i = NST - 2; i >= 0; i--) begin
         adv[i] = !v_ff[i] || adv[i+1];
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = v_ff[NST-1];

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int i = 1; i < NST; i++) begin
            if (adv[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // carry the mode bit alongside
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         mode_ff[0] <= req_iou_mode;
      end
      for (int i = 1; i < NST; i++) begin
         if (adv[i]) begin
            mode_ff[i] <= mode_ff[i-1];
         end
      end
   end

   // stage 0: capture the input word
   logic signed [CW-1:0] s0_tl_ff, s0_tt_ff, s0_tr_ff, s0_tb_ff;
   logic signed [CW-1:0] s0_dl_ff, s0_dt_ff, s0_dr_ff, s0_db_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s0_tl_ff <= req_track_left;
         s0_tt_ff <= req_track_top;
         s0_tr_ff <= req_track_right;
         s0_tb_ff <= req_track_bottom;
         s0_dl_ff <= req_det_left;
         s0_dt_ff <= req_det_top;
         s0_dr_ff <= req_det_right;
         s0_db_ff <= req_det_bottom;
      end
   end

   // stage 1: min/max of edges, signed sizes, doubled centres
   logic signed [CW:0] e_tl, e_tt, e_tr, e_tb, e_dl, e_dt, e_dr, e_db;
   logic signed [CW:0] s1_mnr_in, s1_mxl_in, s1_mnb_in, s1_mxt_in;
   logic signed [CW:0] s1_mxr_in, s1_mnl_in, s1_mxb_in, s1_mnt_in;
   logic signed [CW:0] s1_w1_in, s1_h1_in, s1_w2_in, s1_h2_in;
   logic signed [CW:0] s1_cx1_in, s1_cy1_in, s1_cx2_in, s1_cy2_in;
   logic signed [CW:0] s1_mnr_ff, s1_mxl_ff, s1_mnb_ff, s1_mxt_ff;
   logic signed [CW:0] s1_mxr_ff, s1_mnl_ff, s1_mxb_ff, s1_mnt_ff;
   logic signed [CW:0] s1_w1_ff, s1_h1_ff, s1_w2_ff, s1_h2_ff;
   logic signed [CW:0] s1_cx1_ff, s1_cy1_ff, s1_cx2_ff, s1_cy2_ff;

   assign e_tl = (CW+1)'(s0_tl_ff);
   assign e_tt = (CW+1)'(s0_tt_ff);
   assign e_tr = (CW+1)'(s0_tr_ff);
   assign e_tb = (CW+1)'(s0_tb_ff);
   assign e_dl = (CW+1)'(s0_dl_ff);
   assign e_dt = (CW+1)'(s0_dt_ff);
   assign e_dr = (CW+1)'(s0_dr_ff);
   assign e_db = (CW+1)'(s0_db_ff);

   always_comb begin
      s1_mnr_in = (e_tr < e_dr) ? e_tr : e_dr;
      s1_mxr_in = (e_tr > e_dr) ? e_tr : e_dr;
      s1_mnl_in = (e_tl < e_dl) ? e_tl : e_dl;
      s1_mxl_in = (e_tl > e_dl) ? e_tl : e_dl;
      s1_mnb_in = (e_tb < e_db) ? e_tb : e_db;
      s1_mxb_in = (e_tb > e_db) ? e_tb : e_db;
      s1_mnt_in = (e_tt < e_dt) ? e_tt : e_dt;
      s1_mxt_in = (e_tt > e_dt) ? e_tt : e_dt;
      s1_w1_in  = e_tr - e_tl;
      s1_h1_in  = e_tb - e_tt;
      s1_w2_in  = e_dr - e_dl;
      s1_h2_in  = e_db - e_dt;
      s1_cx1_in = e_tl + e_tr;
      s1_cy1_in = e_tt + e_tb;
      s1_cx2_in = e_dl + e_dr;
      s1_cy2_in = e_dt + e_db;
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_mnr_ff <= s1_mnr_in;
         s1_mxr_ff <= s1_mxr_in;
         s1_mnl_ff <= s1_mnl_in;
         s1_mxl_ff <= s1_mxl_in;
         s1_mnb_ff <= s1_mnb_in;
         s1_mxb_ff <= s1_mxb_in;
         s1_mnt_ff <= s1_mnt_in;
         s1_mxt_ff <= s1_mxt_in;
         s1_w1_ff  <= s1_w1_in;
         s1_h1_ff  <= s1_h1_in;
         s1_w2_ff  <= s1_w2_in;
         s1_h2_ff  <= s1_h2_in;
         s1_cx1_ff <= s1_cx1_in;
         s1_cy1_ff <= s1_cy1_in;
         s1_cx2_ff <= s1_cx2_in;
         s1_cy2_ff <= s1_cy2_in;
      end
   end

   // stage 2: overlap, clamped sizes, size deltas, centre distance and span
   logic signed [CW:0]   iw_s, ih_s, ex_s, ey_s;
   logic signed [CW+1:0] dw_s, dh_s, cdx_s, cdy_s;
   logic [CW:0]          cdx_a, cdy_a, ex_a, ey_a;
   logic [CW-1:0]        s2_iw_in, s2_ih_in, s2_w1p_in, s2_h1p_in, s2_w2p_in, s2_h2p_in;
   logic [CW:0]          s2_dw_in, s2_dh_in;
   logic [DW-1:0]        s2_inner_in, s2_outer_in;
   logic [CW-1:0]        s2_iw_ff, s2_ih_ff, s2_w1p_ff, s2_h1p_ff, s2_w2p_ff, s2_h2p_ff;
   logic [CW:0]          s2_dw_ff, s2_dh_ff;
   logic [DW-1:0]        s2_inner_ff, s2_outer_ff;

   always_comb begin
      iw_s  = s1_mnr_ff - s1_mxl_ff;
      ih_s  = s1_mnb_ff - s1_mxt_ff;
      ex_s  = s1_mxr_ff - s1_mnl_ff;
      ey_s  = s1_mxb_ff - s1_mnt_ff;
      dw_s  = (CW+2)'(s1_w2_ff) - (CW+2)'(s1_w1_ff);
      dh_s  = (CW+2)'(s1_h2_ff) - (CW+2)'(s1_h1_ff);
      cdx_s = (CW+2)'(s1_cx1_ff) - (CW+2)'(s1_cx2_ff);
      cdy_s = (CW+2)'(s1_cy1_ff) - (CW+2)'(s1_cy2_ff);

      // clamp inverted extents to zero
      s2_iw_in  = (iw_s > 0) ? iw_s[CW-1:0] : '0;
      s2_ih_in  = (ih_s > 0) ? ih_s[CW-1:0] : '0;
      s2_w1p_in = (s1_w1_ff > 0) ? s1_w1_ff[CW-1:0] : '0;
      s2_h1p_in = (s1_h1_ff > 0) ? s1_h1_ff[CW-1:0] : '0;
      s2_w2p_in = (s1_w2_ff > 0) ? s1_w2_ff[CW-1:0] : '0;
      s2_h2p_in = (s1_h2_ff > 0) ? s1_h2_ff[CW-1:0] : '0;

      // magnitudes
      s2_dw_in = dw_s[CW+1] ? (CW+1)'(-dw_s) : dw_s[CW:0];
      s2_dh_in = dh_s[CW+1] ? (CW+1)'(-dh_s) : dh_s[CW:0];
      cdx_a    = cdx_s[CW+1] ? (CW+1)'(-cdx_s) : cdx_s[CW:0];
      cdy_a    = cdy_s[CW+1] ? (CW+1)'(-cdy_s) : cdy_s[CW:0];
      ex_a     = ex_s[CW] ? (CW+1)'(-ex_s) : ex_s;
      ey_a     = ey_s[CW] ? (CW+1)'(-ey_s) : ey_s;

      s2_inner_in = DW'(cdx_a) + DW'(cdy_a);
      s2_outer_in = (DW'(ex_a) + DW'(ey_a)) << 1;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_iw_ff    <= s2_iw_in;
         s2_ih_ff    <= s2_ih_in;
         s2_w1p_ff   <= s2_w1p_in;
         s2_h1p_ff   <= s2_h1p_in;
         s2_w2p_ff   <= s2_w2p_in;
         s2_h2p_ff   <= s2_h2p_in;
         s2_dw_ff    <= s2_dw_in;
         s2_dh_ff    <= s2_dh_in;
         s2_inner_ff <= s2_inner_in;
         s2_outer_ff <= s2_outer_in;
      end
   end

   // stage 3: areas, overlap area, similarity denominators
   logic [2*CW-1:0] s3_a1_ff, s3_a2_ff, s3_inter_ff;
   logic [CW-1:0]   s3_iw_ff, s3_ih_ff;
   logic [CW+1:0]   s3_swd_ff, s3_shd_ff;
   logic [DW-1:0]   s3_inner_ff, s3_outer_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_a1_ff    <= s2_w1p_ff * s2_h1p_ff;
         s3_a2_ff    <= s2_w2p_ff * s2_h2p_ff;
         s3_inter_ff <= s2_iw_ff * s2_ih_ff;
         s3_iw_ff    <= s2_iw_ff;
         s3_ih_ff    <= s2_ih_ff;
         s3_swd_ff   <= (CW+2)'(s2_iw_ff) + (CW+2)'(s2_dw_ff);
         s3_shd_ff   <= (CW+2)'(s2_ih_ff) + (CW+2)'(s2_dh_ff);
         s3_inner_ff <= s2_inner_ff;
         s3_outer_ff <= s2_outer_ff;
      end
   end

   // divider operands: union, then the four ratio lanes
   logic [NW-1:0] iou_num, iou_den;
   logic [K:0]    q_iou, q_d, q_sw, q_sh;
   logic          ix_iou, ix_d, ix_sw, ix_sh;

   assign iou_num = NW'(s3_inter_ff);
   assign iou_den = NW'(s3_a1_ff) + NW'(s3_a2_ff) - NW'(s3_inter_ff);

   bpmc_ratio_pipe #(.NW(NW), .K(K)) u_div_iou (
      .clock   (clock),
      .adv     (adv[DS +: K+1]),
      .num     (iou_num),
      .den     (iou_den),
      .quot    (q_iou),
      .inexact (ix_iou)
   );

   bpmc_ratio_pipe #(.NW(NW), .K(K)) u_div_dist (
      .clock   (clock),
      .adv     (adv[DS +: K+1]),
      .num     (NW'(s3_inner_ff)),
      .den     (NW'(s3_outer_ff)),
      .quot    (q_d),
      .inexact (ix_d)
   );

   bpmc_ratio_pipe #(.NW(NW), .K(K)) u_div_sw (
      .clock   (clock),
      .adv     (adv[DS +: K+1]),
      .num     (NW'(s3_iw_ff)),
      .den     (NW'(s3_swd_ff)),
      .quot    (q_sw),
      .inexact (ix_sw)
   );

   bpmc_ratio_pipe #(.NW(NW), .K(K)) u_div_sh (
      .clock   (clock),
      .adv     (adv[DS +: K+1]),
      .num     (NW'(s3_ih_ff)),
      .den     (NW'(s3_shd_ff)),
      .quot    (q_sh),
      .inexact (ix_sh)
   );

   // sum stage: combined numerator from the four ratios, and the IoU-only cost
   logic [K+2:0] num_sum;
   logic         ix16;
   logic [XW-1:0] s5_x_ff;
   logic [F:0]    s5_io_ff;

   assign num_sum = THREE_ONE + (K+3)'(q_d) - (K+3)'(q_iou) - (K+3)'(q_sw)
                    - (K+3)'(q_sh);
   assign ix16    = ix_iou || (q_iou[1:0] != 2'b00);

   always_ff @(posedge clock) begin
      if (adv[DS+K+1]) begin
         s5_x_ff  <= num_sum[K+2:2];
         s5_io_ff <= ONE_F - (F+1)'(q_iou[K:2]) - (F+1)'(ix16);
      end
   end

   // multiply by the reciprocal of three
   logic [XW+RS-1:0] s6_prod_ff;
   logic [F:0]       s6_io_ff;

   always_ff @(posedge clock) begin
      if (adv[DS+K+2]) begin
         s6_prod_ff <= s5_x_ff * RECIP;
         s6_io_ff   <= s5_io_ff;
      end
   end

   // output register: select by mode
   logic [F:0] rsp_cost_ff;

   always_ff @(posedge clock) begin
      if (adv[NST-1]) begin
         rsp_cost_ff <= mode_ff[NST-2] ? s6_io_ff : s6_prod_ff[RS +: F+1];
      end
   end

   assign rsp_match_cost = rsp_cost_ff;

endmodule

FILE: rtl/bpmc_ratio_pipe.sv
// ----------------------------------------------------------------------------
// bpmc_ratio_pipe: pipelined restoring ratio divider
// Computes floor(num * 2^K / den), one quotient bit per stage, saturating to
// 2^K when num reaches den and giving 0 when num is zero. Also flags a
// nonzero final remainder.
// ----------------------------------------------------------------------------
module bpmc_ratio_pipe #(
   parameter int NW = 41,
   parameter int K  = 18
) (
   input  logic          clock,
   input  logic [K:0]    adv,
   input  logic [NW-1:0] num,
   input  logic [NW-1:0] den,
   output logic [K:0]    quot,
   output logic          inexact
);

   logic [NW-1:0] r_ff    [K+1];
   logic [NW-1:0] d_ff    [K+1];
   logic [K-1:0]  q_ff    [K+1];
   logic          zero_ff [K+1];
   logic          sat_ff  [K+1];

   // load operands and classify the special cases
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         r_ff[0]    <= num;
         d_ff[0]    <= den;
         q_ff[0]    <= '0;
         zero_ff[0] <= (num == '0);
         sat_ff[0]  <= (num >= den);
      end
   end

   // one restoring step per stage
   for (genvar j = 1; j <= K; j++) begin : g_step
      logic [NW:0] rem2;
      logic [NW:0] dext;
      logic        ge;

      assign rem2 = {r_ff[j-1], 1'b0};
      assign dext = {1'b0, d_ff[j-1]};
      assign ge   = (rem2 >= dext);

      always_ff @(posedge clock) begin
         if (adv[j]) begin
            r_ff[j]    <= ge ? NW'(rem2 - dext) : rem2[NW-1:0];
            d_ff[j]    <= d_ff[j-1];
            q_ff[j]    <= {q_ff[j-1][K-2:0], ge};
            zero_ff[j] <= zero_ff[j-1];
            sat_ff[j]  <= sat_ff[j-1];
         end
      end
   end

   // apply zero and saturation rules
   always_comb begin
      if (zero_ff[K]) begin
         quot    = '0;
         inexact = 1'b0;
      end else if (sat_ff[K]) begin
         quot    = {1'b1, {K{1'b0}}};
         inexact = 1'b0;
      end else begin
         quot    = {1'b0, q_ff[K]};
         inexact = (r_ff[K] != '0);
      end
   end

endmodule
